// File: hw/rtl/mwdt_pkg.sv
`timescale 1ns / 1ps

package mwdt_pkg;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int BASE_W     = 20;
    localparam int REM_W      = 43;
    localparam int PRE_W      = 5;
    localparam int POST_W     = 3;
    localparam int SHIFT_W    = 6;
    localparam int WIDE_W     = 58;

    localparam logic [BASE_W-1:0] BASE_RESET          = 20'd18000;
    localparam logic [PRE_W-1:0]  PRESCALE_BASE_EXP   = 5'd5;
    localparam logic [PRE_W-1:0]  PRESCALE_RESET_EXP  = 5'd0;
    localparam logic [POST_W-1:0] POSTSCALE_RESET_EXP = 3'd7;
    // The reset base of 18000 scaled by the reset postscale of 128.
    localparam logic [REM_W-1:0]  REM_RESET           = 43'd2304000;
    localparam logic [REM_W-1:0]  REM_MAX             = {REM_W{1'b1}};

    typedef enum logic [2:0] {
        ACT_TICK      = 3'd0,
        ACT_CLEAR     = 3'd1,
        ACT_SW_ENABLE = 3'd2,
        ACT_PRESCALE  = 3'd3,
        ACT_POSTSCALE = 3'd4,
        ACT_POR       = 3'd5,
        ACT_EXT_RESET = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        EVT_NONE  = 2'd0,
        EVT_HALT  = 2'd1,
        EVT_WAKE  = 2'd2,
        EVT_RESET = 2'd3
    } evt_t;

    typedef enum logic [1:0] {
        REG_BASE     = 2'd0,
        REG_FUSE     = 2'd1,
        REG_USE_POST = 2'd2,
        REG_HALT     = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [BASE_W-1:0] base_timeout_cycles;
        logic              fuse_enable;
        logic              use_timer0_postscale;
        logic              halt_on_expiry;
    } cfg_t;

    typedef struct packed {
        logic              base_wr;
        logic              fuse_wr;
        logic [BASE_W-1:0] base_data;
        logic              fuse_data;
    } cfg_wr_t;

    typedef struct packed {
        logic [2:0] action;
        logic [3:0] value;
        logic       cpu_sleeping;
        logic       wake_allowed;
    } item_t;

    typedef struct packed {
        evt_t expiry_event;
        logic clear_timeout_flag;
        logic running;
    } res_t;

    // Full watchdog period with saturation at the counter's range.
    function automatic logic [REM_W-1:0] period_f(
        input logic [BASE_W-1:0] base,
        input logic [PRE_W-1:0]  pre,
        input logic [POST_W-1:0] post,
        input logic              use_post
    );
        logic [SHIFT_W-1:0] sh;
        logic [WIDE_W-1:0]  wide;
        sh = {1'b0, pre} + (use_post ? {3'b000, post} : {SHIFT_W{1'b0}});
        wide = {{(WIDE_W-BASE_W){1'b0}}, base} << sh;
        if (|wide[WIDE_W-1:REM_W])
        begin
            return REM_MAX;
        end
        return wide[REM_W-1:0];
    endfunction

endpackage

// File: hw/rtl/mwdt_item_if.sv
`timescale 1ns / 1ps

interface mwdt_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [3:0] value;
    logic       cpu_sleeping;
    logic       wake_allowed;

    modport source (
        output valid, action, value, cpu_sleeping, wake_allowed,
        input  ready
    );

    modport sink (
        input  valid, action, value, cpu_sleeping, wake_allowed,
        output ready
    );
endinterface

// File: hw/rtl/mwdt_result_if.sv
`timescale 1ns / 1ps

interface mwdt_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] expiry_event;
    logic       clear_timeout_flag;
    logic       running;

    modport source (
        output valid, expiry_event, clear_timeout_flag, running,
        input  ready
    );

    modport sink (
        input  valid, expiry_event, clear_timeout_flag, running,
        output ready
    );
endinterface

// File: hw/rtl/mcu_watchdog_timer.sv
`timescale 1ns / 1ps
// Flow: an accepted request is held in the request register until the result register is free.
// Throughput: one request per cycle while the result output is not stalled; the counter
// update is a single pass from the request register to the result register.
// Reset: asynchronous and active low; registers take their documented reset values,
// the watchdog starts disabled and disarmed, and both pipeline stages are emptied.

module mcu_watchdog_timer (
    input  logic                              clk,
    input  logic                              rst_n,
    mwdt_item_if.sink                         item,
    mwdt_result_if.source                     result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mwdt_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mwdt_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mwdt_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    mwdt_pkg::cfg_t    cfg;
    mwdt_pkg::cfg_wr_t wr;
    mwdt_pkg::res_t    core_res;
    mwdt_pkg::item_t   s1_item_reg;
    mwdt_pkg::res_t    res_reg;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              res_valid_reg;
    logic              res_valid_next;
    logic              out_free;
    logic              step_fire;
    logic              accept;

    assign pready    = 1'b1;
    assign out_free  = !res_valid_reg || result.ready;
    assign step_fire = s1_valid_reg && out_free;
    assign item.ready = !s1_valid_reg || step_fire;
    assign accept    = item.valid && item.ready;

    mwdt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg),
        .wr      (wr)
    );

    mwdt_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .wr    (wr),
        .fire  (step_fire),
        .itm   (s1_item_reg),
        .res   (core_res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (step_fire)
        begin
            s1_valid_next = 1'b0;
        end
        res_valid_next = res_valid_reg;
        if (step_fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg.action       <= item.action;
            s1_item_reg.value        <= item.value;
            s1_item_reg.cpu_sleeping <= item.cpu_sleeping;
            s1_item_reg.wake_allowed <= item.wake_allowed;
        end
        if (step_fire)
        begin
            res_reg <= core_res;
        end
    end

    assign result.valid              = res_valid_reg;
    assign result.expiry_event       = res_reg.expiry_event;
    assign result.clear_timeout_flag = res_reg.clear_timeout_flag;
    assign result.running            = res_reg.running;

    // A request is never taken while the request stage is full and stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!s1_valid_reg || step_fire))
        else $error("request accepted into an occupied, stalled stage");

    // The timeout flag is cleared exactly on wake and reset expiries.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.clear_timeout_flag ==
            ((result.expiry_event == mwdt_pkg::EVT_WAKE) ||
             (result.expiry_event == mwdt_pkg::EVT_RESET))))
        else $error("timeout flag does not match expiry kind");

    // Wake and reset expiries re-arm; a halt expiry leaves the counter stopped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && ((result.expiry_event == mwdt_pkg::EVT_WAKE) ||
                          (result.expiry_event == mwdt_pkg::EVT_RESET)))
        |-> result.running)
        else $error("counter not re-armed after wake or reset expiry");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.expiry_event == mwdt_pkg::EVT_HALT))
        |-> !result.running)
        else $error("counter still running after halt expiry");

endmodule

// File: hw/rtl/mwdt_regs.sv
`timescale 1ns / 1ps

module mwdt_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mwdt_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mwdt_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mwdt_pkg::APB_DATA_W-1:0]   prdata,
    output mwdt_pkg::cfg_t                    cfg,
    output mwdt_pkg::cfg_wr_t                 wr
);

    mwdt_pkg::cfg_t     cfg_reg;
    mwdt_pkg::cfg_t     cfg_next;
    mwdt_pkg::reg_idx_t idx;
    logic               wr_en;

    assign idx   = mwdt_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        cfg_next     = cfg_reg;
        wr           = '0;
        wr.base_data = pwdata[mwdt_pkg::BASE_W-1:0];
        wr.fuse_data = pwdata[0];
        if (wr_en)
        begin
            case (idx)
                mwdt_pkg::REG_BASE:
                begin
                    cfg_next.base_timeout_cycles = pwdata[mwdt_pkg::BASE_W-1:0];
                    wr.base_wr = 1'b1;
                end
                mwdt_pkg::REG_FUSE:
                begin
                    cfg_next.fuse_enable = pwdata[0];
                    wr.fuse_wr = 1'b1;
                end
                mwdt_pkg::REG_USE_POST:
                begin
                    cfg_next.use_timer0_postscale = pwdata[0];
                end
                mwdt_pkg::REG_HALT:
                begin
                    cfg_next.halt_on_expiry = pwdata[0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_timeout_cycles  <= mwdt_pkg::BASE_RESET;
            cfg_reg.fuse_enable          <= 1'b0;
            cfg_reg.use_timer0_postscale <= 1'b1;
            cfg_reg.halt_on_expiry       <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        case (idx)
            mwdt_pkg::REG_BASE:
            begin
                prdata[mwdt_pkg::BASE_W-1:0] = cfg_reg.base_timeout_cycles;
            end
            mwdt_pkg::REG_FUSE:
            begin
                prdata[0] = cfg_reg.fuse_enable;
            end
            mwdt_pkg::REG_USE_POST:
            begin
                prdata[0] = cfg_reg.use_timer0_postscale;
            end
            mwdt_pkg::REG_HALT:
            begin
                prdata[0] = cfg_reg.halt_on_expiry;
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/mwdt_core.sv
`timescale 1ns / 1ps

module mwdt_core (
    input  logic              clk,
    input  logic              rst_n,
    input  mwdt_pkg::cfg_t    cfg,
    input  mwdt_pkg::cfg_wr_t wr,
    input  logic              fire,
    input  mwdt_pkg::item_t   itm,
    output mwdt_pkg::res_t    res
);

    logic                          enabled_reg;
    logic                          enabled_next;
    logic                          armed_reg;
    logic                          armed_next;
    logic [mwdt_pkg::REM_W-1:0]    remaining_reg;
    logic [mwdt_pkg::REM_W-1:0]    remaining_next;
    logic [mwdt_pkg::PRE_W-1:0]    pre_reg;
    logic [mwdt_pkg::PRE_W-1:0]    pre_next;
    logic [mwdt_pkg::POST_W-1:0]   post_reg;
    logic [mwdt_pkg::POST_W-1:0]   post_next;
    logic [mwdt_pkg::PRE_W-1:0]    pre_sel;
    logic [mwdt_pkg::BASE_W-1:0]   base_src;
    logic [mwdt_pkg::REM_W-1:0]    period;
    logic                          do_arm;
    mwdt_pkg::evt_t                evt;
    logic                          clr;

    assign pre_sel  = mwdt_pkg::PRESCALE_BASE_EXP + {1'b0, itm.value};
    assign base_src = wr.base_wr ? wr.base_data : cfg.base_timeout_cycles;
    assign period   = mwdt_pkg::period_f(base_src, pre_next, post_next,
                                         cfg.use_timer0_postscale);

    always_comb
    begin
        enabled_next   = enabled_reg;
        armed_next     = armed_reg;
        remaining_next = remaining_reg;
        pre_next       = pre_reg;
        post_next      = post_reg;
        do_arm         = 1'b0;
        evt            = mwdt_pkg::EVT_NONE;
        clr            = 1'b0;
        if (wr.base_wr)
        begin
            do_arm = 1'b1;
        end
        else if (wr.fuse_wr)
        begin
            enabled_next = wr.fuse_data;
            if (wr.fuse_data)
            begin
                do_arm = 1'b1;
            end
            else
            begin
                armed_next = 1'b0;
            end
        end
        else if (fire)
        begin
            case (mwdt_pkg::action_t'(itm.action))
                mwdt_pkg::ACT_TICK:
                begin
                    if (armed_reg)
                    begin
                        if (|remaining_reg[mwdt_pkg::REM_W-1:1])
                        begin
                            remaining_next = remaining_reg - 1'b1;
                        end
                        else if (!enabled_reg)
                        begin
                            armed_next = 1'b0;
                        end
                        else if (cfg.halt_on_expiry)
                        begin
                            armed_next = 1'b0;
                            evt        = mwdt_pkg::EVT_HALT;
                        end
                        else
                        begin
                            do_arm = 1'b1;
                            clr    = 1'b1;
                            evt    = (itm.cpu_sleeping && itm.wake_allowed) ?
                                     mwdt_pkg::EVT_WAKE : mwdt_pkg::EVT_RESET;
                        end
                    end
                end
                mwdt_pkg::ACT_CLEAR, mwdt_pkg::ACT_POR:
                begin
                    do_arm = 1'b1;
                end
                mwdt_pkg::ACT_SW_ENABLE:
                begin
                    if (!cfg.fuse_enable && (itm.value[0] != enabled_reg))
                    begin
                        enabled_next = itm.value[0];
                        if (itm.value[0])
                        begin
                            do_arm = 1'b1;
                        end
                        else
                        begin
                            armed_next = 1'b0;
                        end
                    end
                end
                mwdt_pkg::ACT_PRESCALE:
                begin
                    if (pre_sel != pre_reg)
                    begin
                        pre_next = pre_sel;
                        do_arm   = 1'b1;
                    end
                end
                mwdt_pkg::ACT_POSTSCALE:
                begin
                    if (itm.value[2:0] != post_reg)
                    begin
                        post_next = itm.value[2:0];
                        do_arm    = 1'b1;
                    end
                end
                mwdt_pkg::ACT_EXT_RESET:
                begin
                    armed_next = 1'b0;
                end
                default:
                begin
                    armed_next = armed_reg;
                end
            endcase
        end
        if (do_arm && enabled_next)
        begin
            armed_next     = 1'b1;
            remaining_next = period;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b0;
            armed_reg     <= 1'b0;
            remaining_reg <= mwdt_pkg::REM_RESET;
            pre_reg       <= mwdt_pkg::PRESCALE_RESET_EXP;
            post_reg      <= mwdt_pkg::POSTSCALE_RESET_EXP;
        end
        else
        begin
            enabled_reg   <= enabled_next;
            armed_reg     <= armed_next;
            remaining_reg <= remaining_next;
            pre_reg       <= pre_next;
            post_reg      <= post_next;
        end
    end

    assign res.expiry_event       = evt;
    assign res.clear_timeout_flag = clr;
    assign res.running            = armed_next;

endmodule

// File: dv/mcu_watchdog_timer_checker.sv
`timescale 1ns / 1ps

module mcu_watchdog_timer_checker
    import mwdt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    mwdt_item_if                  item,
    mwdt_result_if                result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    errors,
    output int                    n_pending,
    output int                    n_checked,
    output int                    n_expiries
);

    logic [BASE_W-1:0] cfg_base;
    logic              cfg_fuse;
    logic              cfg_use_post;
    logic              cfg_halt;

    logic              wd_enabled;
    logic              wd_armed;
    logic [REM_W-1:0]  wd_left;
    logic [PRE_W-1:0]  wd_pre;
    logic [POST_W-1:0] wd_post;

    res_t              expected_q[$];
    res_t              exp_r;
    res_t              new_r;
    logic              bad;

    function automatic logic [REM_W-1:0] timeout_period();
        logic [5:0]  shift;
        logic [63:0] scaled;
        shift = {1'b0, wd_pre};
        if (cfg_use_post)
        begin
            shift = shift + {3'b000, wd_post};
        end
        scaled = {44'd0, cfg_base} << shift;
        if (scaled[63:REM_W] != '0)
        begin
            return {REM_W{1'b1}};
        end
        return scaled[REM_W-1:0];
    endfunction

    function automatic void rearm();
        if (wd_enabled)
        begin
            wd_armed = 1'b1;
            wd_left  = timeout_period();
        end
    endfunction

    function automatic void reset_watchdog();
        cfg_base     = 20'd18000;
        cfg_fuse     = 1'b0;
        cfg_use_post = 1'b1;
        cfg_halt     = 1'b0;
        wd_pre       = 5'd0;
        wd_post      = 3'd7;
        wd_enabled   = 1'b0;
        wd_armed     = 1'b0;
        wd_left      = timeout_period();
    endfunction

    function automatic res_t watchdog_step(input logic [2:0] act, input logic [3:0] val,
                                           input logic sleeping, input logic wake_ok);
        res_t             r;
        logic [PRE_W-1:0] new_pre;
        r.expiry_event       = EVT_NONE;
        r.clear_timeout_flag = 1'b0;
        case (action_t'(act))
            ACT_TICK:
            begin
                if (wd_armed)
                begin
                    if (wd_left > 1)
                    begin
                        wd_left = wd_left - 1'b1;
                    end
                    else if (!wd_enabled)
                    begin
                        wd_armed = 1'b0;
                    end
                    else if (cfg_halt)
                    begin
                        wd_armed       = 1'b0;
                        r.expiry_event = EVT_HALT;
                    end
                    else
                    begin
                        rearm();
                        r.clear_timeout_flag = 1'b1;
                        r.expiry_event = (sleeping && wake_ok) ? EVT_WAKE : EVT_RESET;
                    end
                end
            end
            ACT_CLEAR, ACT_POR:
            begin
                rearm();
            end
            ACT_SW_ENABLE:
            begin
                if (!cfg_fuse && (val[0] != wd_enabled))
                begin
                    wd_enabled = val[0];
                    if (wd_enabled)
                    begin
                        rearm();
                    end
                    else
                    begin
                        wd_armed = 1'b0;
                    end
                end
            end
            ACT_PRESCALE:
            begin
                new_pre = PRESCALE_BASE_EXP + {1'b0, val};
                if (new_pre != wd_pre)
                begin
                    wd_pre = new_pre;
                    rearm();
                end
            end
            ACT_POSTSCALE:
            begin
                if (val[2:0] != wd_post)
                begin
                    wd_post = val[2:0];
                    rearm();
                end
            end
            ACT_EXT_RESET:
            begin
                wd_armed = 1'b0;
            end
            default:
            begin
            end
        endcase
        r.running = wd_armed;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_watchdog();
            expected_q.delete();
            errors     <= 0;
            n_pending  <= 0;
            n_checked  <= 0;
            n_expiries <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_BASE:
                    begin
                        cfg_base = pwdata[BASE_W-1:0];
                        rearm();
                    end
                    REG_FUSE:
                    begin
                        cfg_fuse   = pwdata[0];
                        wd_enabled = cfg_fuse;
                        if (wd_enabled)
                        begin
                            rearm();
                        end
                        else
                        begin
                            wd_armed = 1'b0;
                        end
                    end
                    REG_USE_POST:
                    begin
                        cfg_use_post = pwdata[0];
                    end
                    REG_HALT:
                    begin
                        cfg_halt = pwdata[0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (result.valid && result.ready)
            begin
                bad = 1'b0;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result: event %0d flag %0b running %0b",
                             $time, result.expiry_event, result.clear_timeout_flag,
                             result.running);
                    bad = 1'b1;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (result.expiry_event !== exp_r.expiry_event)
                    begin
                        $display("%0t: expiry_event mismatch: expected %0d, actual %0d",
                                 $time, exp_r.expiry_event, result.expiry_event);
                        bad = 1'b1;
                    end
                    if (result.clear_timeout_flag !== exp_r.clear_timeout_flag)
                    begin
                        $display("%0t: clear_timeout_flag mismatch: expected %0b, actual %0b",
                                 $time, exp_r.clear_timeout_flag, result.clear_timeout_flag);
                        bad = 1'b1;
                    end
                    if (result.running !== exp_r.running)
                    begin
                        $display("%0t: running mismatch: expected %0b, actual %0b",
                                 $time, exp_r.running, result.running);
                        bad = 1'b1;
                    end
                end
                n_checked <= n_checked + 1;
                if (bad)
                begin
                    errors <= errors + 1;
                end
            end

            if (item.valid && item.ready)
            begin
                new_r = watchdog_step(item.action, item.value, item.cpu_sleeping,
                                      item.wake_allowed);
                if (new_r.expiry_event != EVT_NONE)
                begin
                    n_expiries <= n_expiries + 1;
                end
                expected_q.push_back(new_r);
            end
            n_pending <= expected_q.size();
        end
    end

endmodule

// File: dv/mcu_watchdog_timer_tb.sv
`timescale 1ns / 1ps

module mcu_watchdog_timer_tb;
    import mwdt_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int errors;
    int n_pending;
    int n_checked;
    int n_expiries;
    int n_settings = 0;
    int stall_left = 0;
    bit calm = 1'b0;

    mwdt_item_if   item_ch();
    mwdt_result_if result_ch();

    mcu_watchdog_timer DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    mcu_watchdog_timer_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .errors     (errors),
        .n_pending  (n_pending),
        .n_checked  (n_checked),
        .n_expiries (n_expiries)
    );

    always #2 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left      <= stall_left - 1;
            result_ch.ready <= 1'b0;
        end
        else if (!calm && ($urandom_range(0, 5) == 0))
        begin
            stall_left      <= pick_gap();
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= 1'b1;
        end
    end

    task automatic send_item(input action_t act, input logic [3:0] val,
                             input logic slp, input logic wk);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.action       <= act;
        item_ch.value        <= val;
        item_ch.cpu_sleeping <= slp;
        item_ch.wake_allowed <= wk;
        @(negedge clk);
        while (!item_ch.ready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    task automatic reg_write(input reg_idx_t idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (n_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        #5000000;
        $display("mcu_watchdog_timer verification failed");
        $finish;
    end

    initial
    begin
        int          r;
        logic [3:0]  val;
        logic [19:0] base;
        rst_n                <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        item_ch.valid        <= 1'b0;
        item_ch.action       <= ACT_TICK;
        item_ch.value        <= 4'd0;
        item_ch.cpu_sleeping <= 1'b0;
        item_ch.wake_allowed <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Disabled watchdog at reset settings, enable and scale writes with and without change.
        send_item(ACT_TICK, 4'd0, 1'b0, 1'b0);
        send_item(ACT_CLEAR, 4'd0, 1'b0, 1'b0);
        send_item(ACT_SW_ENABLE, 4'd0, 1'b0, 1'b0);
        send_item(ACT_POSTSCALE, 4'd11, 1'b0, 1'b0);
        send_item(ACT_POSTSCALE, 4'd7, 1'b0, 1'b0);
        send_item(ACT_SW_ENABLE, 4'd1, 1'b1, 1'b1);
        send_item(ACT_SW_ENABLE, 4'd1, 1'b0, 1'b0);
        send_item(ACT_EXT_RESET, 4'd0, 1'b0, 1'b0);
        send_item(ACT_POR, 4'd0, 1'b0, 1'b0);
        send_item(ACT_SW_ENABLE, 4'd0, 1'b0, 1'b0);
        drain();

        // A period of one tick gives reset and wake expiries on consecutive ticks.
        reg_write(REG_BASE, 32'd1);
        reg_write(REG_USE_POST, 32'd0);
        n_settings++;
        send_item(ACT_SW_ENABLE, 4'd1, 1'b0, 1'b0);
        send_item(ACT_TICK, 4'd0, 1'b0, 1'b1);
        send_item(ACT_TICK, 4'd15 & 4'd11, 1'b1, 1'b1);
        send_item(ACT_TICK, 4'd0, 1'b1, 1'b0);
        drain();

        // Halt expiry leaves the counter disarmed until a clear.
        reg_write(REG_HALT, 32'd1);
        n_settings++;
        send_item(ACT_TICK, 4'd0, 1'b0, 1'b0);
        send_item(ACT_TICK, 4'd0, 1'b0, 1'b0);
        send_item(ACT_CLEAR, 4'd0, 1'b0, 1'b0);
        send_item(ACT_PRESCALE, 4'd11, 1'b0, 1'b0);
        send_item(ACT_PRESCALE, 4'd11, 1'b0, 1'b0);
        send_item(ACT_PRESCALE, 4'd0, 1'b0, 1'b0);
        send_item(ACT_SW_ENABLE, 4'd0, 1'b0, 1'b0);
        drain();

        // Fuse on with the largest base and postscale; software disable is ignored.
        reg_write(REG_FUSE, 32'd1);
        reg_write(REG_BASE, 32'd1048575);
        reg_write(REG_USE_POST, 32'd1);
        reg_write(REG_HALT, 32'd0);
        n_settings++;
        send_item(ACT_SW_ENABLE, 4'd10, 1'b0, 1'b0);
        send_item(ACT_PRESCALE, 4'd11, 1'b0, 1'b0);
        send_item(ACT_POSTSCALE, 4'd7, 1'b0, 1'b0);
        send_item(ACT_TICK, 4'd5, 1'b1, 1'b0);
        send_item(ACT_EXT_RESET, 4'd0, 1'b0, 1'b0);
        send_item(ACT_CLEAR, 4'd0, 1'b0, 1'b0);
        drain();
        reg_write(REG_FUSE, 32'd0);
        n_settings++;

        for (int phase = 0; phase < 10; phase++)
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
            begin
                base = $urandom_range(1, 3);
            end
            else if (r < 9)
            begin
                base = $urandom_range(4, 40);
            end
            else
            begin
                base = $urandom_range(1, 1048575);
            end
            reg_write(REG_BASE, {12'd0, base});
            reg_write(REG_FUSE, {31'd0, 1'($urandom_range(0, 1))});
            reg_write(REG_USE_POST, {31'd0, 1'($urandom_range(0, 1))});
            reg_write(REG_HALT, {31'd0, 1'($urandom_range(0, 1))});
            n_settings++;
            calm <= (phase == 3) || (phase == 7);

            send_item(ACT_SW_ENABLE, 4'd1, 1'b0, 1'b0);
            send_item(ACT_PRESCALE, 4'd0, 1'b0, 1'b0);
            send_item(ACT_POSTSCALE, 4'($urandom_range(0, 1)), 1'b0, 1'b0);
            repeat (110)
            begin
                r   = $urandom_range(0, 99);
                val = 4'($urandom_range(0, 11));
                if (r < 78)
                begin
                    send_item(ACT_TICK, val, 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                end
                else if (r < 83)
                begin
                    send_item(ACT_CLEAR, val, 1'($urandom_range(0, 1)), 1'b0);
                end
                else if (r < 88)
                begin
                    val[0] = ($urandom_range(0, 9) != 0);
                    val    = (val > 4'd11) ? {1'b0, val[2:0]} : val;
                    send_item(ACT_SW_ENABLE, val, 1'b0, 1'($urandom_range(0, 1)));
                end
                else if (r < 92)
                begin
                    if ($urandom_range(0, 3) != 0)
                    begin
                        val = 4'd0;
                    end
                    send_item(ACT_PRESCALE, val, 1'($urandom_range(0, 1)), 1'b0);
                end
                else if (r < 96)
                begin
                    if ($urandom_range(0, 2) != 0)
                    begin
                        val = {1'($urandom_range(0, 1)), 2'b00, 1'($urandom_range(0, 1))};
                    end
                    send_item(ACT_POSTSCALE, val, 1'b0, 1'($urandom_range(0, 1)));
                end
                else if (r < 98)
                begin
                    send_item(ACT_POR, val, 1'b0, 1'b0);
                end
                else
                begin
                    send_item(ACT_EXT_RESET, val, 1'($urandom_range(0, 1)), 1'b0);
                end
            end
            drain();
        end

        $display("Checked %0d results against prediction, %0d of them expiry events.",
                 n_checked, n_expiries);
        $display("Register settings exercised: %0d, with random idling on both channels.",
                 n_settings);
        if (errors == 0)
        begin
            $display("mcu_watchdog_timer verification clean");
        end
        else
        begin
            $display("mcu_watchdog_timer verification failed");
        end
        $finish;
    end

endmodule
